>>> hw/rtl/swtm_pkg.sv
package swtm_pkg;

  localparam int SampleBits = 16;
  localparam int AddrBits   = 8;
  localparam int LenBits    = 9;
  localparam int TrimBits   = 7;
  localparam int SumBits    = 24;
  localparam int WinDepth   = 256;
  localparam int DivSteps   = 24;
  localparam int CntBits    = 5;

  localparam logic [LenBits-1:0]  LEN_RESET  = 9'd256;
  localparam logic [LenBits-1:0]  LEN_MAX    = 9'd256;
  localparam logic [TrimBits-1:0] TRIM_RESET = 7'd16;

  // register indexes
  localparam logic [7:0] CFG_WINDOW_LENGTH = 8'd0;
  localparam logic [7:0] CFG_TRIM_COUNT    = 8'd1;

  // controller states, also used as datapath phase codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RING = 3'd1;
  localparam logic [2:0] ST_REM  = 3'd2;
  localparam logic [2:0] ST_INS  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  typedef struct packed {
    logic       load;
    logic [2:0] phase;
    logic       first;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic done;
  } status_t;

endpackage

>>> hw/rtl/swtm_ctrl.sv
module swtm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  swtm_pkg::status_t stat,
  output swtm_pkg::cmd_t    cmd
);

  logic [2:0] state;
  logic [2:0] state_next;
  logic       first;
  logic       out_load;

  assign in_ready = (state == swtm_pkg::ST_IDLE);

  // sequence the phases of one item
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      swtm_pkg::ST_IDLE: if (in_valid) state_next = swtm_pkg::ST_RING;
      swtm_pkg::ST_RING: state_next = stat.full ? swtm_pkg::ST_REM : swtm_pkg::ST_INS;
      swtm_pkg::ST_REM:  if (stat.done) state_next = swtm_pkg::ST_INS;
      swtm_pkg::ST_INS:  if (stat.done) state_next = swtm_pkg::ST_SUM;
      swtm_pkg::ST_SUM:  if (stat.done) state_next = swtm_pkg::ST_DIV;
      swtm_pkg::ST_DIV:  if (stat.done) state_next = swtm_pkg::ST_DONE;
      swtm_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = swtm_pkg::ST_IDLE;
        end
      end
      default: state_next = swtm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load     = in_valid && in_ready;
    cmd.phase    = state;
    cmd.first    = first;
    cmd.out_load = out_load;
  end

  // hold state and the result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= swtm_pkg::ST_IDLE;
      first     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      first <= (state_next != state);
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/swtm_datapath.sv
module swtm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  swtm_pkg::cmd_t                    cmd,
  output swtm_pkg::status_t                 stat,
  input  logic [swtm_pkg::SampleBits-1:0]   sample,
  input  logic                              cfg_we,
  input  logic [7:0]                        cfg_index,
  input  logic [swtm_pkg::LenBits-1:0]      cfg_data,
  output logic [swtm_pkg::SampleBits-1:0]   trimmed_mean,
  output logic                              mean_valid
);

  logic [swtm_pkg::SampleBits-1:0] ring [swtm_pkg::WinDepth];
  logic [swtm_pkg::SampleBits-1:0] srt  [swtm_pkg::WinDepth];

  logic [swtm_pkg::LenBits-1:0]    window_length;
  logic [swtm_pkg::TrimBits-1:0]   trim_count;
  logic [swtm_pkg::LenBits-1:0]    fill;
  logic [swtm_pkg::AddrBits-1:0]   op;
  logic [swtm_pkg::SampleBits-1:0] smp;
  logic [swtm_pkg::SampleBits-1:0] old;
  logic [swtm_pkg::SampleBits-1:0] srt_q;
  logic [swtm_pkg::LenBits-1:0]    idx;
  logic [swtm_pkg::AddrBits-1:0]   pa;
  logic                            pv;
  logic                            found;
  logic                            stop;
  logic [swtm_pkg::SumBits-1:0]    acc;
  logic [swtm_pkg::LenBits-1:0]    rem;
  logic [swtm_pkg::SumBits-1:0]    quo;
  logic [swtm_pkg::CntBits-1:0]    dcnt;

  logic [swtm_pkg::LenBits-1:0]    mlen;
  logic [swtm_pkg::LenBits-1:0]    twok;
  logic [swtm_pkg::LenBits-1:0]    divisor;
  logic                            full;
  logic                            win_ok;
  logic                            run;
  logic                            issue;
  logic                            stop_next;
  logic                            done;
  logic [swtm_pkg::AddrBits-1:0]   srt_raddr;
  logic                            srt_we;
  logic [swtm_pkg::AddrBits-1:0]   srt_waddr;
  logic [swtm_pkg::SampleBits-1:0] srt_wdata;
  logic [swtm_pkg::AddrBits-1:0]   ring_addr;
  logic                            ring_en;
  logic [swtm_pkg::LenBits:0]      shifted;
  logic                            qbit;

  // clamp the window length into its legal range
  always_comb begin
    if (window_length == '0) mlen = swtm_pkg::LenBits'(1);
    else if (window_length > swtm_pkg::LEN_MAX) mlen = swtm_pkg::LEN_MAX;
    else mlen = window_length;
  end

  assign twok    = {1'b0, trim_count, 1'b0};
  assign divisor = mlen - twok;
  assign full    = (fill == mlen);
  assign win_ok  = (mlen > twok);
  assign run     = !cmd.first;

  assign stat.full = full;
  assign stat.done = done;

  // ring buffer: fetch the evicted sample while writing the new one
  assign ring_en   = (cmd.phase == swtm_pkg::ST_RING);
  assign ring_addr = full ? op : fill[swtm_pkg::AddrBits-1:0];

  always_ff @(posedge clk) begin
    if (ring_en) begin
      old             <= ring[ring_addr];
      ring[ring_addr] <= smp;
    end
  end

  // walk control for the sorted copy
  always_comb begin
    issue     = 1'b0;
    srt_raddr = idx[swtm_pkg::AddrBits-1:0];
    srt_we    = 1'b0;
    srt_waddr = pa;
    srt_wdata = srt_q;
    stop_next = stop;
    done      = 1'b0;
    case (cmd.phase)
      swtm_pkg::ST_RING: done = 1'b1;
      swtm_pkg::ST_REM: if (run) begin
        issue = (idx < fill);
        if (pv && found) begin
          srt_we    = 1'b1;
          srt_waddr = pa - swtm_pkg::AddrBits'(1);
        end
        done = !issue && !pv;
      end
      swtm_pkg::ST_INS: if (run) begin
        stop_next = stop || (pv && !(srt_q > smp));
        if (pv && !stop) begin
          srt_we    = 1'b1;
          srt_waddr = pa + swtm_pkg::AddrBits'(1);
          srt_wdata = (srt_q > smp) ? srt_q : smp;
        end else if (!pv && !stop && idx == '0) begin
          srt_we    = 1'b1;
          srt_waddr = '0;
          srt_wdata = smp;
          stop_next = 1'b1;
        end
        issue     = (idx != '0) && !stop_next;
        srt_raddr = idx[swtm_pkg::AddrBits-1:0] - swtm_pkg::AddrBits'(1);
        done      = stop;
      end
      swtm_pkg::ST_SUM: if (run) begin
        issue = ({1'b0, idx} + {3'b0, trim_count}) < {1'b0, fill};
        done  = !issue && !pv;
      end
      swtm_pkg::ST_DIV: done = run && (dcnt == swtm_pkg::CntBits'(swtm_pkg::DivSteps));
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    srt_q <= srt[srt_raddr];
    if (srt_we) srt[srt_waddr] <= srt_wdata;
  end

  // one restoring division step
  assign shifted = {rem, quo[swtm_pkg::SumBits-1]};
  assign qbit    = (shifted >= {1'b0, divisor});

  // advance counters, accumulators and the divider
  always_ff @(posedge clk) begin
    if (cmd.load) smp <= sample;
    case (cmd.phase)
      swtm_pkg::ST_REM: begin
        if (cmd.first) begin
          idx   <= '0;
          pv    <= 1'b0;
          found <= 1'b0;
        end else begin
          pv <= issue;
          pa <= idx[swtm_pkg::AddrBits-1:0];
          if (issue) idx <= idx + swtm_pkg::LenBits'(1);
          if (pv && !found && srt_q == old) found <= 1'b1;
        end
      end
      swtm_pkg::ST_INS: begin
        if (cmd.first) begin
          idx  <= fill;
          pv   <= 1'b0;
          stop <= 1'b0;
        end else begin
          pv   <= issue;
          pa   <= srt_raddr;
          stop <= stop_next;
          if (issue) idx <= idx - swtm_pkg::LenBits'(1);
        end
      end
      swtm_pkg::ST_SUM: begin
        if (cmd.first) begin
          idx <= {2'b0, trim_count};
          pv  <= 1'b0;
          acc <= '0;
        end else begin
          pv <= issue;
          if (issue) idx <= idx + swtm_pkg::LenBits'(1);
          if (pv) acc <= acc + {8'b0, srt_q};
        end
      end
      swtm_pkg::ST_DIV: begin
        if (cmd.first) begin
          quo  <= acc;
          rem  <= '0;
          dcnt <= '0;
        end else if (!done) begin
          rem  <= qbit ? swtm_pkg::LenBits'(shifted - {1'b0, divisor})
                       : shifted[swtm_pkg::LenBits-1:0];
          quo  <= {quo[swtm_pkg::SumBits-2:0], qbit};
          dcnt <= dcnt + swtm_pkg::CntBits'(1);
        end
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      mean_valid   <= full && win_ok;
      trimmed_mean <= (full && win_ok) ? quo[swtm_pkg::SampleBits-1:0] : '0;
    end
  end

  // configuration and window occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= swtm_pkg::LEN_RESET;
      trim_count    <= swtm_pkg::TRIM_RESET;
      fill          <= '0;
      op            <= '0;
    end else begin
      if (cfg_we && cfg_index == swtm_pkg::CFG_WINDOW_LENGTH) begin
        window_length <= cfg_data;
        fill          <= '0;
        op            <= '0;
      end else if (cfg_we && cfg_index == swtm_pkg::CFG_TRIM_COUNT) begin
        trim_count <= cfg_data[swtm_pkg::TrimBits-1:0];
      end
      if (ring_en && full) begin
        op <= (({1'b0, op} + swtm_pkg::LenBits'(1)) == mlen) ? '0
                                                             : op + swtm_pkg::AddrBits'(1);
      end
      if (cmd.phase == swtm_pkg::ST_REM && done) fill <= fill - swtm_pkg::LenBits'(1);
      if (cmd.phase == swtm_pkg::ST_INS && done) fill <= fill + swtm_pkg::LenBits'(1);
    end
  end

endmodule

>>> hw/rtl/sliding_window_trimmed_mean_unit.sv
// Sliding-window trimmed mean: each sample item enters a window of the last
// window_length samples, clamped to 1 to 256 (a write to window_length empties
// the window), and yields one result item, the floor of the window's sum
// without its trim_count smallest and largest samples divided by the window
// length minus twice trim_count; mean_valid stays low until the window is full
// or when the trim is too large, and trimmed_mean is then zero. One item is in
// work at a time. The sorted copy sits in a memory with one read and one write
// port, walked once to drop the evicted sample when the window is full, once
// to insert the new one (the insertion walk stops at its slot, so it is
// shorter when the new sample sorts near the top) and once to add up the
// middle entries, followed by a 24-step serial divider. A finished result
// waits in its output register while the next sample item is taken.
// Configuration is taken only while the block is idle.
module sliding_window_trimmed_mean_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [swtm_pkg::SampleBits-1:0] sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [swtm_pkg::SampleBits-1:0] trimmed_mean,
  output logic                            mean_valid,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [7:0]                      cfg_index,
  input  logic [swtm_pkg::LenBits-1:0]    cfg_data
);

  swtm_pkg::cmd_t    cmd;
  swtm_pkg::status_t stat;

  // take register writes only between items
  assign cfg_ready = in_ready;

  swtm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swtm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (sample),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .trimmed_mean (trimmed_mean),
    .mean_valid   (mean_valid)
  );

  // one item at a time
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in work");

  // an invalid mean reads as zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !mean_valid) |-> (trimmed_mean == '0))
    else $error("nonzero mean without mean_valid");

  // results are issued only from the final phase
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (cmd.phase == swtm_pkg::ST_DONE && !in_ready))
    else $error("result loaded outside the final phase");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

// Trimmed-mean predictor and result store
class trim_mean_board;
  typedef struct {
    logic [15:0] mean;
    logic        valid;
  } mean_t;

  logic [15:0] window_q[$];
  mean_t       expected_q[$];
  int unsigned win_len;
  int unsigned trim;
  int          errors;
  int          checked;

  function new();
    win_len = 256;
    trim    = 16;
  endfunction

  // Any length write empties the window; zero and oversize lengths are clamped
  function void set_length(logic [8:0] v);
    if (v == 0) win_len = 1;
    else if (v > 256) win_len = 256;
    else win_len = v;
    window_q.delete();
  endfunction

  function void set_trim(logic [8:0] v);
    trim = v[6:0];
  endfunction

  function void report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endfunction

  // Advance the window by one sample and store the expected mean
  function void note_sample(logic [15:0] s);
    logic [15:0] sorted[$];
    int unsigned sum;
    int unsigned n;
    mean_t e;
    window_q.push_back(s);
    if (window_q.size() > win_len) void'(window_q.pop_front());
    sorted = window_q;
    sorted.sort();
    n = sorted.size();
    sum = 0;
    if (n > 2 * trim)
      for (int unsigned i = trim; i < n - trim; i++) sum += sorted[i];
    e.valid = (n == win_len) && (win_len > 2 * trim);
    e.mean  = e.valid ? 16'(sum / (win_len - 2 * trim)) : 16'd0;
    expected_q.push_back(e);
  endfunction

  function void check_result(logic [15:0] mean, logic valid);
    mean_t e;
    checked++;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result mean=%0d valid=%0b", mean, valid));
      return;
    end
    e = expected_q.pop_front();
    if (valid !== e.valid)
      report($sformatf("result %0d: mean_valid %0b, want %0b", checked, valid, e.valid));
    if (mean !== e.mean)
      report($sformatf("result %0d: trimmed_mean %0d, want %0d", checked, mean, e.mean));
  endfunction
endclass

module tb_top;
  import swtm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] trimmed_mean;
  logic        mean_valid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = CFG_WINDOW_LENGTH;
  logic [8:0]  cfg_data = '0;

  trim_mean_board board = new();
  bit          steady;
  int          cycles;
  int          sent;
  int          cfg_writes;

  sliding_window_trimmed_mean_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .trimmed_mean(trimmed_mean), .mean_valid(mean_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Random back-pressure on the result side
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(99) >= 20);
  end

  // Watch both handshakes
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_sample(sample);
    if (!rst && out_valid && out_ready) board.check_result(trimmed_mean, mean_valid);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_sample(logic [15:0] s);
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Hold input low until every expected item has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [8:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WINDOW_LENGTH) board.set_length(v);
    else if (idx == CFG_TRIM_COUNT) board.set_trim(v);
    cfg_writes++;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom_range(7));
      1: return 16'($urandom_range(65535, 65528));
      default: return 16'($urandom);
    endcase
  endfunction

  // The second block of sixty items in a long phase always runs without idling
  task automatic run_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) steady = (i == 60) || ($urandom_range(3) == 0);
      send_sample(pick_sample());
    end
    drain();
  endtask

  initial begin
    int m;
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes at the reset setting, window not full
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    for (int b = 0; b < 16; b++) send_sample(16'(1 << b));
    drain();
    // Small window with duplicates and both extremes
    write_reg(CFG_WINDOW_LENGTH, 9'd3);
    write_reg(CFG_TRIM_COUNT, 9'd0);
    send_sample(16'hFFFF); send_sample(16'hFFFF); send_sample(16'h0000);
    send_sample(16'hFFFF); send_sample(16'h0000);
    drain();
    // Zero length behaves as one
    write_reg(CFG_WINDOW_LENGTH, 9'd0);
    send_sample(16'h1234); send_sample(16'hFFFF);
    drain();
    // Trim too large
    write_reg(CFG_WINDOW_LENGTH, 9'd2);
    write_reg(CFG_TRIM_COUNT, 9'd1);
    send_sample(16'h00FF); send_sample(16'h0F0F); send_sample(16'hAAAA);
    drain();
    // Unknown register index is ignored
    write_reg(8'd7, 9'd5);
    write_reg(8'hFF, 9'h1FF);
    send_sample(16'h5555);
    drain();

    // Oversize length saturates; largest trim still leaves two samples
    write_reg(CFG_WINDOW_LENGTH, 9'h1FF);
    write_reg(CFG_TRIM_COUNT, 9'd127);
    run_phase(270);
    // Trim change keeps the window
    write_reg(CFG_TRIM_COUNT, 9'd0);
    run_phase(10);

    // Random small settings
    for (int p = 0; p < 14; p++) begin
      m = $urandom_range(24, 1);
      k = $urandom_range(12);
      if ($urandom_range(3) != 0) write_reg(CFG_WINDOW_LENGTH, 9'(m));
      write_reg(CFG_TRIM_COUNT, 9'(k));
      for (int i = 0; i < 20; i++) send_sample(pick_sample());
      // Pause until every result is back, then continue the same window
      drain();
      run_phase(20);
    end

    $display("Sent %0d samples, checked %0d results over %0d register writes.",
             sent, board.checked, cfg_writes);
    $display("Covered clamped lengths, oversized trims, partial and full windows.");
    if (board.errors == 0 && board.expected_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/swtm_pkg.sv
hw/rtl/swtm_ctrl.sv
hw/rtl/swtm_datapath.sv
hw/rtl/sliding_window_trimmed_mean_unit.sv
tb/sv/tb_top.sv
